>>> hdl/stsq_pkg.sv
// Shared types and constants of the servo turnout sequencer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package stsq_pkg;

  localparam int AngleW = 8;
  localparam int CountW = 9;

  // Tick counts for power switch-on settling and power hold after a move
  localparam logic [CountW-1:0] PowerWait = 9'd200;
  localparam logic [CountW-1:0] PowerHold = 9'd500;

  // Operation codes carried in tuser
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_COMMAND = 2'd1,
    OP_POWERUP = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  // Turnout states; bit 0 is the goal endpoint (1 = thrown), bit 1 marks motion
  typedef enum logic [1:0] {
    ST_CLOSED   = 2'd0,
    ST_THROWN   = 2'd1,
    ST_CLOSING  = 2'd2,
    ST_THROWING = 2'd3
  } turnout_state_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_THROW_ANGLE     = 3'd0,
    REG_STEP_TICKS      = 3'd1,
    REG_INVERT_OP       = 3'd2,
    REG_INVERT_FROG     = 3'd3,
    REG_HAS_POWER_SW    = 3'd4,
    REG_HAS_FROG_OUT    = 3'd5,
    REG_IGNORE_SAVED    = 3'd6,
    REG_ACTIVATE_ON_PU  = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [AngleW-1:0] throw_angle;
    logic [7:0]        step_ticks;
    logic              invert_operation;
    logic              invert_frog;
    logic              has_power_switch;
    logic              has_frog_output;
    logic              ignore_saved_state;
    logic              activate_on_power_up;
  } cfg_t;

  // Result item, packed so that the last field sits in the lowest bits
  typedef struct packed {
    logic              command_accepted;
    logic              reached_endpoint;
    logic [1:0]        motion_state;
    logic              reported_active;
    logic              frog_high;
    logic              power_enabled;
    logic [AngleW-1:0] servo_angle;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/stsq_cfg.sv
// Configuration register file of the servo turnout sequencer.
// Depends on stsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stsq_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [7:0]        cfg_data,
  output stsq_pkg::cfg_t         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.throw_angle          <= 8'd180;
      cfg.step_ticks           <= 8'd10;
      cfg.invert_operation     <= 1'b0;
      cfg.invert_frog          <= 1'b0;
      cfg.has_power_switch     <= 1'b0;
      cfg.has_frog_output      <= 1'b0;
      cfg.ignore_saved_state   <= 1'b0;
      cfg.activate_on_power_up <= 1'b0;
    end else if (cfg_write) begin
      unique case (stsq_pkg::reg_index_t'(cfg_index))
        stsq_pkg::REG_THROW_ANGLE:    cfg.throw_angle          <= cfg_data;
        stsq_pkg::REG_STEP_TICKS:     cfg.step_ticks           <= cfg_data;
        stsq_pkg::REG_INVERT_OP:      cfg.invert_operation     <= cfg_data[0];
        stsq_pkg::REG_INVERT_FROG:    cfg.invert_frog          <= cfg_data[0];
        stsq_pkg::REG_HAS_POWER_SW:   cfg.has_power_switch     <= cfg_data[0];
        stsq_pkg::REG_HAS_FROG_OUT:   cfg.has_frog_output      <= cfg_data[0];
        stsq_pkg::REG_IGNORE_SAVED:   cfg.ignore_saved_state   <= cfg_data[0];
        stsq_pkg::REG_ACTIVATE_ON_PU: cfg.activate_on_power_up <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/stsq_core.sv
// Turnout state registers and the combinational update for one request.
// Depends on stsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stsq_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [1:0]       operation,
  input  wire logic             requested_active,
  input  wire stsq_pkg::cfg_t   cfg,
  output stsq_pkg::result_t     result
);

  stsq_pkg::turnout_state_t state, state_next;
  logic [7:0] position, position_next;
  logic [8:0] countdown, countdown_next;
  logic       power_flag, power_flag_next;
  logic       frog_level, frog_level_next;

  logic [8:0] count_dec;
  logic [7:0] target;
  logic       goal;
  logic       reached;
  logic       accepted;

  always_comb begin
    state_next      = state;
    position_next   = position;
    countdown_next  = countdown;
    power_flag_next = power_flag;
    frog_level_next = frog_level;
    reached         = 1'b0;
    accepted        = 1'b0;
    goal            = 1'b0;
    count_dec       = (countdown != 9'd0) ? countdown - 9'd1 : 9'd0;
    target          = state[0] ? cfg.throw_angle : 8'd0;

    unique case (stsq_pkg::op_t'(operation))
      stsq_pkg::OP_TICK: begin
        countdown_next = count_dec;
        if (!state[1]) begin
          // settled: drop power once the hold time has run out
          if (power_flag && count_dec == 9'd0 && cfg.has_power_switch)
            power_flag_next = 1'b0;
        end else if (position == target) begin
          countdown_next = stsq_pkg::PowerHold;
          state_next     = state[0] ? stsq_pkg::ST_THROWN : stsq_pkg::ST_CLOSED;
          reached        = 1'b1;
          if (cfg.has_frog_output)
            frog_level_next = state[0] ^ cfg.invert_frog;
        end else if (count_dec == 9'd0) begin
          position_next  = state[0] ? position + 8'd1 : position - 8'd1;
          countdown_next = {1'b0, cfg.step_ticks};
        end
      end
      stsq_pkg::OP_COMMAND: begin
        goal = requested_active ^ cfg.invert_operation;
        if (goal != state[0]) begin
          accepted = 1'b1;
          state_next = goal ? stsq_pkg::ST_THROWING : stsq_pkg::ST_CLOSING;
          if (cfg.has_power_switch) begin
            power_flag_next = 1'b1;
            countdown_next  = stsq_pkg::PowerWait;
          end
        end
      end
      stsq_pkg::OP_POWERUP: begin
        // power goes off then straight back on, so only the switch-on stays
        goal = cfg.ignore_saved_state & (cfg.activate_on_power_up ^ cfg.invert_operation);
        position_next = goal ? cfg.throw_angle : 8'd0;
        state_next    = goal ? stsq_pkg::ST_THROWING : stsq_pkg::ST_CLOSING;
        if (cfg.has_power_switch) begin
          power_flag_next = 1'b1;
          countdown_next  = stsq_pkg::PowerWait;
        end
      end
      default: ;
    endcase

    result.servo_angle      = position_next;
    result.power_enabled    = power_flag_next;
    result.frog_high        = frog_level_next;
    // a moving state reports the endpoint it is leaving
    result.reported_active  = state_next[1] ^ state_next[0] ^ cfg.invert_operation;
    result.motion_state     = state_next;
    result.reached_endpoint = reached;
    result.command_accepted = accepted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= stsq_pkg::ST_CLOSED;
      position   <= 8'd0;
      countdown  <= 9'd0;
      power_flag <= 1'b0;
      frog_level <= 1'b0;
    end else if (accept) begin
      state      <= state_next;
      position   <= position_next;
      countdown  <= countdown_next;
      power_flag <= power_flag_next;
      frog_level <= frog_level_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/stsq_skid.sv
// Output register with a skid stage for result items.
// Depends on stsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stsq_skid (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire stsq_pkg::result_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output stsq_pkg::result_t       out_data
);

  logic              skid_valid;
  stsq_pkg::result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && !skid_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

>>> hdl/servo_turnout_sequencer.sv
// Top level of the servo turnout sequencer.
// Depends on stsq_pkg, stsq_cfg, stsq_core and stsq_skid.
//
// Usage:
//   s_* channel: one request per tick, server command or power-up init.
//     s_tuser carries the operation code, s_tdata[0] the requested level.
//   m_* channel: exactly one result request per input request, in order,
//     carrying servo angle, power, frog level, reported state, motion state
//     and the reached / accepted flags.
//   cfg_*: plain register writes, taken at any edge with cfg_write high;
//     write only while no request is in flight.
// Each result is registered at the edge that accepts its input.
// Throughput: one request per cycle while s_tready is high; the whole update
//   is one combinational pass from the state registers into the output register.
// Stall: a skid stage behind the output register takes one more result
//   while the receiver holds m_tready low; s_tready drops only once that
//   stage is full and rises again when the output drains.
// Reset (rst, synchronous): state closed, angle 0, countdown 0, power and
//   frog low, registers at defaults (throw 180, step 10, flags 0), no
//   result pending.
`timescale 1ns / 1ps
`default_nettype none

module servo_turnout_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  // input requests
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] requested_active, [7:1] zero
  input  wire logic [1:0]  s_tuser,   // [1:0] operation
  // result requests
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] servo_angle, [8] power_enabled,
                                      // [9] frog_high, [10] reported_active,
                                      // [12:11] motion_state, [13] reached_endpoint,
                                      // [14] command_accepted, [15] zero
  // configuration writes
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  stsq_pkg::cfg_t    cfg;
  stsq_pkg::result_t core_result;
  stsq_pkg::result_t out_result;
  logic              accept;

  assign accept = s_tvalid && s_tready;

  stsq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // state update happens in the same cycle the request is accepted
  stsq_core u_core (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .operation        (s_tuser),
    .requested_active (s_tdata[0]),
    .cfg              (cfg),
    .result           (core_result)
  );

  stsq_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_ready  (s_tready),
    .in_data   (core_result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tdata = {1'b0, out_result};

`ifndef SYNTHESIS
  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // finishing a move always lands on an endpoint state
  a_reached_settled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[13]) |-> !m_tdata[12])
    else $error("endpoint reached but still moving");

  // an accepted command always starts motion
  a_accept_moving: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[14]) |-> m_tdata[12])
    else $error("command accepted without a move");

  // a result not taken is held for the receiver
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for servo_turnout_sequencer: stream driver, result monitor
// and a cycle-free turnout predictor with its own copy of state and registers.
// Depends on stsq_pkg and the servo_turnout_sequencer RTL.
`timescale 1ns / 1ps

module tb_top;
  import stsq_pkg::*;

  // One input request as queued for the driver
  typedef struct packed {
    op_t  op;
    logic want_active;
  } turnout_request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic [1:0]  s_tuser = 2'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [7:0]  cfg_data = 8'd0;

  servo_turnout_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Requests waiting for the driver, results waiting for the monitor
  turnout_request_t pending_requests[$];
  result_t          pending_results[$];

  // Pacing knobs (percent of cycles idle / stalled) and the long receiver hold-off
  int idle_pct  = 0;
  int stall_pct = 0;
  int rx_hold   = 0;
  int mismatches = 0;

  // Set by the monitor when the offered request was taken at this rising edge
  logic in_taken = 1'b0;

  // Predictor copy of the turnout and its registers
  turnout_state_t      seq_state;
  logic [AngleW-1:0]   seq_angle;
  logic [CountW-1:0]   seq_wait;
  logic                seq_power;
  logic                seq_frog;
  cfg_t                seq_cfg;

  turnout_request_t next_req;
  result_t          got_result;
  result_t          want_result;

  // Advance the predicted turnout by one request and return the result it shows
  function automatic result_t turnout_step(input op_t op, input logic want_active);
    result_t           r;
    logic              up;
    logic              goal;
    logic [AngleW-1:0] target;
    logic              reached;
    logic              accepted;
    reached  = 1'b0;
    accepted = 1'b0;
    case (op)
      OP_TICK: begin
        // countdown saturates at zero, then the state decides what is due
        if (seq_wait != '0) seq_wait = seq_wait - 9'd1;
        case (seq_state)
          ST_CLOSED, ST_THROWN: begin
            if (seq_power && seq_wait == '0 && seq_cfg.has_power_switch) seq_power = 1'b0;
          end
          default: begin
            up     = (seq_state == ST_THROWING);
            target = up ? seq_cfg.throw_angle : '0;
            // endpoint check comes ahead of the countdown; angle wraps if the
            // endpoint was moved behind the servo
            if (seq_angle == target) begin
              seq_wait  = PowerHold;
              seq_state = up ? ST_THROWN : ST_CLOSED;
              if (seq_cfg.has_frog_output) seq_frog = up ^ seq_cfg.invert_frog;
              reached = 1'b1;
            end else if (seq_wait == '0) begin
              seq_angle = up ? seq_angle + 8'd1 : seq_angle - 8'd1;
              seq_wait  = {1'b0, seq_cfg.step_ticks};
            end
          end
        endcase
      end
      OP_COMMAND: begin
        goal = want_active ^ seq_cfg.invert_operation;
        // same goal as already targeted is dropped
        if (goal != ((seq_state == ST_THROWN) || (seq_state == ST_THROWING))) begin
          if (seq_cfg.has_power_switch) begin
            seq_power = 1'b1;
            seq_wait  = PowerWait;
          end
          seq_state = goal ? ST_THROWING : ST_CLOSING;
          accepted  = 1'b1;
        end
      end
      OP_POWERUP: begin
        if (seq_cfg.has_power_switch) seq_power = 1'b0;
        goal = seq_cfg.ignore_saved_state ?
               (seq_cfg.activate_on_power_up ^ seq_cfg.invert_operation) : 1'b0;
        seq_angle = goal ? seq_cfg.throw_angle : '0;
        if (seq_cfg.has_power_switch) begin
          seq_power = 1'b1;
          seq_wait  = PowerWait;
        end
        seq_state = goal ? ST_THROWING : ST_CLOSING;
      end
      default: ;  // unused code leaves everything alone
    endcase
    r.servo_angle      = seq_angle;
    r.power_enabled    = seq_power;
    r.frog_high        = seq_frog;
    // a moving state still reports the endpoint it is leaving
    r.reported_active  = ((seq_state == ST_THROWN) || (seq_state == ST_CLOSING)) ^
                         seq_cfg.invert_operation;
    r.motion_state     = seq_state;
    r.reached_endpoint = reached;
    r.command_accepted = accepted;
    return r;
  endfunction

  // Driver: holds a request until taken, otherwise offers the next one or idles
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_req = pending_requests.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= next_req.op;
        s_tdata  <= {7'd0, next_req.want_active};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off counted down here
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: check results against the oldest prediction, predict taken requests
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got_result = m_tdata[14:0];
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result %h at %0t", m_tdata, $realtime);
          mismatches = mismatches + 1;
        end else begin
          want_result = pending_results.pop_front();
          if (got_result.servo_angle      !== want_result.servo_angle      ||
              got_result.power_enabled    !== want_result.power_enabled    ||
              got_result.frog_high        !== want_result.frog_high        ||
              got_result.reported_active  !== want_result.reported_active  ||
              got_result.motion_state     !== want_result.motion_state     ||
              got_result.reached_endpoint !== want_result.reached_endpoint ||
              got_result.command_accepted !== want_result.command_accepted) begin
            if (mismatches < 10) begin
              $display("mismatch at %0t (exp/got): angle %0d/%0d pwr %b/%b frog %b/%b",
                       $realtime,
                       want_result.servo_angle, got_result.servo_angle,
                       want_result.power_enabled, got_result.power_enabled,
                       want_result.frog_high, got_result.frog_high);
              $display("  act %b/%b state %0d/%0d reach %b/%b acc %b/%b",
                       want_result.reported_active, got_result.reported_active,
                       want_result.motion_state, got_result.motion_state,
                       want_result.reached_endpoint, got_result.reached_endpoint,
                       want_result.command_accepted, got_result.command_accepted);
            end
            mismatches = mismatches + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        pending_results.push_back(turnout_step(op_t'(s_tuser), s_tdata[0]));
        in_taken = 1'b1;
      end
    end
  end

  task automatic push_req(input op_t op, input logic want_active);
    turnout_request_t r;
    r.op          = op;
    r.want_active = want_active;
    pending_requests.push_back(r);
  endtask

  // Register write while idle; predictor copy follows at once
  task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_THROW_ANGLE:    seq_cfg.throw_angle          = value;
      REG_STEP_TICKS:     seq_cfg.step_ticks           = value;
      REG_INVERT_OP:      seq_cfg.invert_operation     = value[0];
      REG_INVERT_FROG:    seq_cfg.invert_frog          = value[0];
      REG_HAS_POWER_SW:   seq_cfg.has_power_switch     = value[0];
      REG_HAS_FROG_OUT:   seq_cfg.has_frog_output      = value[0];
      REG_IGNORE_SAVED:   seq_cfg.ignore_saved_state   = value[0];
      REG_ACTIVATE_ON_PU: seq_cfg.activate_on_power_up = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Sender stops feeding until every predicted result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || s_tvalid || pending_results.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // Small endpoints and short steps keep moves affordable
  task automatic random_setup(input int max_throw);
    write_reg(REG_THROW_ANGLE, 8'($urandom_range(max_throw)));
    write_reg(REG_STEP_TICKS, 8'($urandom_range(3)));
    write_reg(REG_INVERT_OP, 8'($urandom_range(1)));
    write_reg(REG_INVERT_FROG, 8'($urandom_range(1)));
    write_reg(REG_HAS_POWER_SW, 8'($urandom_range(1)));
    write_reg(REG_HAS_FROG_OUT, 8'($urandom_range(1)));
    write_reg(REG_IGNORE_SAVED, 8'($urandom_range(1)));
    write_reg(REG_ACTIVATE_ON_PU, 8'($urandom_range(1)));
  endtask

  // Mostly command-then-ticks sequences; some long tick runs so that the
  // power wait and the step train play out; rest is noise. Tick runs are
  // cut short so a phase queues exactly count requests.
  task automatic queue_random(input int count);
    int queued;
    int pick;
    int ticks;
    queued = 0;
    while (queued < count) begin
      pick = $urandom_range(99);
      ticks = 0;
      if (pick < 60) begin
        push_req(OP_COMMAND, 1'($urandom_range(1)));
        ticks = $urandom_range(1, 12);
      end else if (pick < 70) begin
        push_req(OP_COMMAND, 1'($urandom_range(1)));
        ticks = $urandom_range(200, 720);
      end else if (pick < 80) begin
        push_req(OP_POWERUP, 1'($urandom_range(1)));
        ticks = $urandom_range(1, 4);
      end else begin
        push_req(op_t'($urandom_range(3)), 1'($urandom_range(1)));
      end
      if (ticks > count - queued - 1)
        ticks = count - queued - 1;
      repeat (ticks) push_req(OP_TICK, 1'($urandom_range(1)));
      queued = queued + 1 + ticks;
    end
  endtask

  initial begin
    seq_state = ST_CLOSED;
    seq_angle = '0;
    seq_wait  = '0;
    seq_power = 1'b0;
    seq_frog  = 1'b0;
    seq_cfg.throw_angle          = 8'd180;
    seq_cfg.step_ticks           = 8'd10;
    seq_cfg.invert_operation     = 1'b0;
    seq_cfg.invert_frog          = 1'b0;
    seq_cfg.has_power_switch     = 1'b0;
    seq_cfg.has_frog_output      = 1'b0;
    seq_cfg.ignore_saved_state   = 1'b0;
    seq_cfg.activate_on_power_up = 1'b0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: no power switch, frog driven and inverted, power-up goes thrown
    write_reg(REG_THROW_ANGLE, 8'd255);
    write_reg(REG_STEP_TICKS, 8'd0);
    write_reg(REG_INVERT_OP, 8'd0);
    write_reg(REG_INVERT_FROG, 8'd1);
    write_reg(REG_HAS_POWER_SW, 8'd0);
    write_reg(REG_HAS_FROG_OUT, 8'd1);
    write_reg(REG_IGNORE_SAVED, 8'd1);
    write_reg(REG_ACTIVATE_ON_PU, 8'd1);
    push_req(OP_TICK, 1'b0);
    push_req(OP_UNUSED, 1'b1);
    push_req(OP_COMMAND, 1'b0);     // already heading closed: dropped
    push_req(OP_POWERUP, 1'b0);     // jumps to 255, throwing
    wait_drained();
    // endpoint pulled below the servo mid-move: angle wraps past 255
    write_reg(REG_THROW_ANGLE, 8'd1);
    repeat (4) push_req(OP_TICK, 1'b0);
    push_req(OP_COMMAND, 1'b1);     // same goal
    push_req(OP_COMMAND, 1'b0);     // start closing; countdown kept, no switch
    push_req(OP_TICK, 1'b1);
    push_req(OP_COMMAND, 1'b1);     // reverse while moving
    push_req(OP_TICK, 1'b0);
    push_req(OP_POWERUP, 1'b1);
    wait_drained();

    // Directed: power switch, no frog output, inverted operation, saved default
    write_reg(REG_THROW_ANGLE, 8'd0);
    write_reg(REG_STEP_TICKS, 8'd255);
    write_reg(REG_INVERT_OP, 8'd1);
    write_reg(REG_INVERT_FROG, 8'd0);
    write_reg(REG_HAS_POWER_SW, 8'd1);
    write_reg(REG_HAS_FROG_OUT, 8'd0);
    write_reg(REG_IGNORE_SAVED, 8'd0);
    write_reg(REG_ACTIVATE_ON_PU, 8'd0);
    push_req(OP_POWERUP, 1'b0);
    push_req(OP_TICK, 1'b0);
    push_req(OP_COMMAND, 1'b0);
    push_req(OP_TICK, 1'b1);
    push_req(OP_COMMAND, 1'b1);
    push_req(OP_COMMAND, 1'b1);     // same goal while moving
    push_req(OP_UNUSED, 1'b0);
    push_req(OP_TICK, 1'b0);
    wait_drained();

    // Random, no idling; receiver holds off long while requests keep coming
    random_setup(6);
    idle_pct  = 0;
    stall_pct = 0;
    queue_random(215);
    @(posedge clk);
    rx_hold = $urandom_range(250, 400);
    wait_drained();

    // Random, sender idles often; endpoints at the zero extreme
    random_setup(0);
    idle_pct  = 59;
    stall_pct = 0;
    queue_random(215);
    wait_drained();

    // Random, receiver stalls often
    random_setup(8);
    idle_pct  = 0;
    stall_pct = 59;
    queue_random(215);
    wait_drained();

    // Random, both sides idle now and then
    random_setup(5);
    idle_pct  = 25;
    stall_pct = 25;
    queue_random(215);
    wait_drained();

    repeat (5) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
